/* rtl/core/sezla_pkg.sv */
// shared constants and the arctangent table for the look-angle pipeline
// no dependencies; compiled first
package sezla_pkg;

    localparam int GUARD_BITS   = 4;
    localparam int ANG_ACC_W    = 34;
    localparam int ATAN_ENTRIES = 31;
    localparam int Q30_FRAC     = 30;

    localparam logic [29:0] INV_GAIN_Q30  = 30'd652032874;
    localparam logic [29:0] INV_GAIN_TAIL = 30'd434688582;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            24:      val = 32'd41;
            25:      val = 32'd20;
            26:      val = 32'd10;
            27:      val = 32'd5;
            28:      val = 32'd3;
            29:      val = 32'd1;
            30:      val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/core/sezla_if.sv */
// valid/ready channel interfaces for the vector input and the look-angle result
// no dependencies
interface sezla_in_if #(parameter int COORD_BITS = 27);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] south_m;
    logic signed [COORD_BITS-1:0] east_m;
    logic signed [COORD_BITS-1:0] zenith_m;

    modport source (output valid, south_m, east_m, zenith_m, input ready);
    modport sink   (input valid, south_m, east_m, zenith_m, output ready);
endinterface

interface sezla_out_if #(parameter int COORD_BITS = 27, parameter int ANGLE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [COORD_BITS-1:0]        slant_range_m;
    logic [ANGLE_BITS-1:0]        azimuth_bam;
    logic signed [ANGLE_BITS-1:0] elevation_bam;
    logic                         zero_vector;

    modport source (output valid, slant_range_m, azimuth_bam, elevation_bam, zero_vector,
                    input ready);
    modport sink   (input valid, slant_range_m, azimuth_bam, elevation_bam, zero_vector,
                    output ready);
endinterface

/* rtl/core/sezla_cordic_stage.sv */
// one registered vectoring cordic micro-rotation with side-band pass-through
// depends on sezla_pkg
module sezla_cordic_stage
    import sezla_pkg::*;
#(
    parameter int W      = 35,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic signed [W-1:0]         x_in,
    input  logic signed [W-1:0]         y_in,
    input  logic signed [ANG_ACC_W-1:0] ang_in,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        valid_out,
    output logic signed [W-1:0]         x_out,
    output logic signed [W-1:0]         y_out,
    output logic signed [ANG_ACC_W-1:0] ang_out,
    output logic [SIDE_W-1:0]           side_out
);

    logic signed [W-1:0]         dx;
    logic signed [W-1:0]         dy;
    logic signed [ANG_ACC_W-1:0] step;
    logic signed [W-1:0]         x_next;
    logic signed [W-1:0]         y_next;
    logic signed [ANG_ACC_W-1:0] ang_next;
    logic                        valid_reg;
    logic signed [W-1:0]         x_reg;
    logic signed [W-1:0]         y_reg;
    logic signed [ANG_ACC_W-1:0] ang_reg;
    logic [SIDE_W-1:0]           side_reg;

    assign step = $signed({{(ANG_ACC_W-32){1'b0}}, atan_turn(SHIFT)});
    assign dx   = y_in >>> SHIFT;
    assign dy   = x_in >>> SHIFT;

    always_comb
    begin
        if (!y_in[W-1])
        begin
            x_next   = x_in + dx;
            y_next   = y_in - dy;
            ang_next = ang_in + step;
        end
        else
        begin
            x_next   = x_in - dx;
            y_next   = y_in + dy;
            ang_next = ang_in - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign ang_out   = ang_reg;
    assign side_out  = side_reg;

endmodule

/* rtl/core/sezla_gain_mul.sv */
// two-stage q30 gain correction multiplier, rounds half up, side-band pass-through
// depends on sezla_pkg
module sezla_gain_mul
    import sezla_pkg::*;
#(
    parameter int          VW     = 34,
    parameter int          PW     = 35,
    parameter int          SIDE_W = 1,
    parameter logic [29:0] GAIN   = 30'd652032874
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [VW-1:0]     v_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [PW-1:0]     p_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int VX = (VW > Q30_FRAC + 1) ? VW : Q30_FRAC + 1;
    localparam int HW = VX - Q30_FRAC;

    logic [VX-1:0]       vx;
    logic [HW+29:0]      hi_next;
    logic [59:0]         lo_next;
    logic [HW+30:0]      sum;
    logic                valid_a_reg;
    logic                valid_b_reg;
    logic [HW+29:0]      hi_reg;
    logic [59:0]         lo_reg;
    logic [SIDE_W-1:0]   side_a_reg;
    logic [SIDE_W-1:0]   side_b_reg;
    logic [PW-1:0]       p_reg;

    assign vx      = VX'(v_in);
    assign hi_next = (HW+30)'(vx[VX-1:Q30_FRAC]) * (HW+30)'(GAIN);
    assign lo_next = 60'(vx[Q30_FRAC-1:0]) * 60'(GAIN);
    assign sum     = (HW+31)'(hi_reg) + (HW+31)'((lo_reg + 60'(64'd1 << 29)) >> Q30_FRAC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= valid_in;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            side_a_reg <= side_in;
            p_reg      <= PW'(sum);
            side_b_reg <= side_a_reg;
        end
    end

    assign valid_out = valid_b_reg;
    assign p_out     = p_reg;
    assign side_out  = side_b_reg;

endmodule

/* rtl/core/sez_look_angles.sv */
// Look angles of a topocentric south/east/zenith vector: slant range, azimuth
// from north through east and elevation, by two unrolled vectoring cordics with
// gain correction. One item is accepted every cycle while the skid register is
// empty. The path from acceptance to result runs through the input stage, a chain
// of CORDIC_STEPS registered micro-rotations and a two-stage gain multiplier for
// azimuth, the same again for elevation, and the output register. A skid register
// behind the output takes one item when the output stalls, and while it is full
// the pipeline and the input stall; a zero vector raises zero_vector and gives zero range and angles.
// depends on sezla_pkg, sezla_if, sezla_cordic_stage, sezla_gain_mul
module sez_look_angles
    import sezla_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_BITS   = 27,
    parameter int ANGLE_BITS   = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    sezla_in_if.sink     vec_in,
    sezla_out_if.source  look_out
);

    localparam int W       = COORD_BITS + GUARD_BITS + 4;
    localparam int VW      = W - 1;
    localparam int PROD_W  = ((VW > 31) ? VW : 31) + 1;
    localparam int DROP    = 32 - ANGLE_BITS;
    localparam int S1_SIDE = COORD_BITS + 2;
    localparam int S2_SIDE = ANGLE_BITS + 1;
    localparam int M1_SIDE = COORD_BITS + ANGLE_BITS + 1;
    localparam int M2_SIDE = 2 * ANGLE_BITS + 1;
    localparam int RES_W   = COORD_BITS + 2 * ANGLE_BITS + 1;

    localparam logic [29:0] INV_GAIN =
        INV_GAIN_Q30 + 30'(INV_GAIN_TAIL >> (2 * CORDIC_STEPS));
    localparam logic [31:0] AZ_ROUND = 32'(64'd1 << (31 - ANGLE_BITS));
    localparam logic signed [ANG_ACC_W-1:0] EL_ROUND =
        ANG_ACC_W'(64'd1 << (31 - ANGLE_BITS));
    localparam logic signed [ANG_ACC_W-1:0] QTR_POS =
        ANG_ACC_W'(64'd1 << (ANGLE_BITS - 2));
    localparam logic signed [ANG_ACC_W-1:0] QTR_NEG = -QTR_POS;
    localparam logic signed [ANGLE_BITS-1:0] EL_MAX =
        ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));
    localparam logic [PROD_W:0] RMAX = (PROD_W+1)'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [PROD_W:0] R_ROUND = (PROD_W+1)'(64'd1 << (GUARD_BITS - 1));

    logic en;

    // input stage
    logic signed [W-1:0]          s_ext;
    logic signed [W-1:0]          e_ext;
    logic signed [W-1:0]          x_raw;
    logic signed [W-1:0]          y_raw;
    logic                         horiz_zero;
    logic                         all_zero;
    logic                         pre_valid_reg;
    logic signed [W-1:0]          pre_x_reg;
    logic signed [W-1:0]          pre_y_reg;
    logic signed [ANG_ACC_W-1:0]  pre_ang_reg;
    logic [S1_SIDE-1:0]           pre_side_reg;

    assign s_ext      = W'(vec_in.south_m);
    assign e_ext      = W'(vec_in.east_m);
    assign x_raw      = -(s_ext <<< GUARD_BITS);
    assign y_raw      = e_ext <<< GUARD_BITS;
    assign horiz_zero = (vec_in.south_m == '0) && (vec_in.east_m == '0);
    assign all_zero   = horiz_zero && (vec_in.zenith_m == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= vec_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // left half plane: turn by a half turn first
            if (x_raw[W-1])
            begin
                pre_x_reg   <= -x_raw;
                pre_y_reg   <= -y_raw;
                pre_ang_reg <= ANG_ACC_W'(64'd1 << 31);
            end
            else
            begin
                pre_x_reg   <= x_raw;
                pre_y_reg   <= y_raw;
                pre_ang_reg <= '0;
            end
            pre_side_reg <= {vec_in.zenith_m, all_zero, horiz_zero};
        end
    end

    // azimuth cordic
    logic                        v1   [CORDIC_STEPS+1];
    logic signed [W-1:0]         x1   [CORDIC_STEPS+1];
    logic signed [W-1:0]         y1   [CORDIC_STEPS+1];
    logic signed [ANG_ACC_W-1:0] a1   [CORDIC_STEPS+1];
    logic [S1_SIDE-1:0]          sd1  [CORDIC_STEPS+1];

    assign v1[0]  = pre_valid_reg;
    assign x1[0]  = pre_x_reg;
    assign y1[0]  = pre_y_reg;
    assign a1[0]  = pre_ang_reg;
    assign sd1[0] = pre_side_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_az_stage
        sezla_cordic_stage #(.W(W), .SHIFT(i), .SIDE_W(S1_SIDE)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (v1[i]),
            .x_in      (x1[i]),
            .y_in      (y1[i]),
            .ang_in    (a1[i]),
            .side_in   (sd1[i]),
            .valid_out (v1[i+1]),
            .x_out     (x1[i+1]),
            .y_out     (y1[i+1]),
            .ang_out   (a1[i+1]),
            .side_out  (sd1[i+1])
        );
    end

    logic [31:0]             az_sum;
    logic [ANGLE_BITS-1:0]   az_bam;
    logic [VW-1:0]           mag1;
    logic                    s1_hz;
    logic                    s1_zero;
    logic [COORD_BITS-1:0]   s1_z;

    assign s1_hz   = sd1[CORDIC_STEPS][0];
    assign s1_zero = sd1[CORDIC_STEPS][1];
    assign s1_z    = sd1[CORDIC_STEPS][S1_SIDE-1:2];
    assign az_sum  = a1[CORDIC_STEPS][31:0] + AZ_ROUND;
    assign az_bam  = s1_hz ? '0 : az_sum[31:DROP];
    assign mag1    = (s1_hz || x1[CORDIC_STEPS][W-1]) ? '0 : x1[CORDIC_STEPS][VW-1:0];

    logic                 m1_valid;
    logic [PROD_W-1:0]    m1_prod;
    logic [M1_SIDE-1:0]   m1_side;

    sezla_gain_mul #(.VW(VW), .PW(PROD_W), .SIDE_W(M1_SIDE), .GAIN(INV_GAIN)) u_gain_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v1[CORDIC_STEPS]),
        .v_in      (mag1),
        .side_in   ({s1_z, az_bam, s1_zero}),
        .valid_out (m1_valid),
        .p_out     (m1_prod),
        .side_out  (m1_side)
    );

    // elevation cordic
    logic                        v2   [CORDIC_STEPS+1];
    logic signed [W-1:0]         x2   [CORDIC_STEPS+1];
    logic signed [W-1:0]         y2   [CORDIC_STEPS+1];
    logic signed [ANG_ACC_W-1:0] a2   [CORDIC_STEPS+1];
    logic [S2_SIDE-1:0]          sd2  [CORDIC_STEPS+1];
    logic signed [COORD_BITS-1:0] m1_z;

    assign m1_z   = $signed(m1_side[M1_SIDE-1:ANGLE_BITS+1]);
    assign v2[0]  = m1_valid;
    assign x2[0]  = $signed(W'(m1_prod));
    assign y2[0]  = W'(m1_z) <<< GUARD_BITS;
    assign a2[0]  = '0;
    assign sd2[0] = m1_side[ANGLE_BITS:0];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_el_stage
        sezla_cordic_stage #(.W(W), .SHIFT(i), .SIDE_W(S2_SIDE)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (v2[i]),
            .x_in      (x2[i]),
            .y_in      (y2[i]),
            .ang_in    (a2[i]),
            .side_in   (sd2[i]),
            .valid_out (v2[i+1]),
            .x_out     (x2[i+1]),
            .y_out     (y2[i+1]),
            .ang_out   (a2[i+1]),
            .side_out  (sd2[i+1])
        );
    end

    logic signed [ANG_ACC_W-1:0]  el_round;
    logic signed [ANG_ACC_W-1:0]  el_shift;
    logic signed [ANG_ACC_W-1:0]  el_clamp;
    logic [VW-1:0]                mag2;

    assign el_round = a2[CORDIC_STEPS] + EL_ROUND;
    assign el_shift = el_round >>> DROP;
    assign mag2     = x2[CORDIC_STEPS][W-1] ? '0 : x2[CORDIC_STEPS][VW-1:0];

    always_comb
    begin
        if (el_shift > QTR_POS)
        begin
            el_clamp = QTR_POS;
        end
        else if (el_shift < QTR_NEG)
        begin
            el_clamp = QTR_NEG;
        end
        else
        begin
            el_clamp = el_shift;
        end
    end

    logic                 m2_valid;
    logic [PROD_W-1:0]    m2_prod;
    logic [M2_SIDE-1:0]   m2_side;

    sezla_gain_mul #(.VW(VW), .PW(PROD_W), .SIDE_W(M2_SIDE), .GAIN(INV_GAIN)) u_gain_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v2[CORDIC_STEPS]),
        .v_in      (mag2),
        .side_in   ({sd2[CORDIC_STEPS][S2_SIDE-1:1], el_clamp[ANGLE_BITS-1:0],
                     sd2[CORDIC_STEPS][0]}),
        .valid_out (m2_valid),
        .p_out     (m2_prod),
        .side_out  (m2_side)
    );

    // result formatting
    logic [PROD_W:0]        rng_full;
    logic [PROD_W:0]        rng_sat;
    logic                   res_zero;
    logic [RES_W-1:0]       res;

    assign res_zero = m2_side[0];
    assign rng_full = ((PROD_W+1)'(m2_prod) + R_ROUND) >> GUARD_BITS;
    assign rng_sat  = (rng_full > RMAX) ? RMAX : rng_full;
    assign res      = res_zero ? {{(RES_W-1){1'b0}}, 1'b1}
                               : {rng_sat[COORD_BITS-1:0], m2_side[M2_SIDE-1:1], 1'b0};

    // output register with skid
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [RES_W-1:0]     out_data_reg;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic [RES_W-1:0]     skid_data_reg;
    logic                 out_fire;
    logic                 load_out_pipe;
    logic                 load_out_skid;
    logic                 load_skid;

    assign en       = !skid_valid_reg;
    assign out_fire = out_valid_reg && look_out.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_pipe   = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                load_out_skid   = 1'b1;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_next = m2_valid;
            load_out_pipe  = 1'b1;
        end
        else if (m2_valid)
        begin
            skid_valid_next = 1'b1;
            load_skid       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (load_out_pipe)
        begin
            out_data_reg <= res;
        end
        if (load_skid)
        begin
            skid_data_reg <= res;
        end
    end

    assign vec_in.ready           = en;
    assign look_out.valid         = out_valid_reg;
    assign look_out.slant_range_m = out_data_reg[RES_W-1:2*ANGLE_BITS+1];
    assign look_out.azimuth_bam   = out_data_reg[2*ANGLE_BITS:ANGLE_BITS+1];
    assign look_out.elevation_bam = $signed(out_data_reg[ANGLE_BITS:1]);
    assign look_out.zero_vector   = out_data_reg[0];

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !look_out.ready) |=> skid_valid_reg)
        else $error("skid item dropped while output stalled");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && look_out.zero_vector) |->
        (look_out.slant_range_m == '0 && look_out.azimuth_bam == '0 &&
         look_out.elevation_bam == '0))
        else $error("zero vector item with nonzero fields");

    a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        (look_out.elevation_bam <= EL_MAX && look_out.elevation_bam >= -EL_MAX))
        else $error("elevation beyond a quarter turn");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for sez_look_angles: vectors in, range/azimuth/elevation out
// predicts every result with its own cordic model; needs sezla_pkg, sezla_if and the rtl
module testbench;
    import sezla_pkg::*;

    localparam int COORD_W = 27;
    localparam int ANGLE_W = 16;
    localparam int STEPS   = 16;
    localparam int LATENCY = 2 * STEPS + 6;

    localparam logic signed [COORD_W-1:0] C_MAX = 27'sd67108863;
    localparam logic signed [COORD_W-1:0] C_MIN = 27'h4000000;

    localparam longint unsigned INV_GAIN  = 64'(INV_GAIN_Q30) + (64'(INV_GAIN_TAIL) >> (2 * STEPS));
    localparam longint unsigned RANGE_MAX = (64'd1 << COORD_W) - 1;
    localparam longint          QUARTER   = 64'sd1 << (ANGLE_W - 2);

    typedef struct packed {
        logic signed [COORD_W-1:0] south;
        logic signed [COORD_W-1:0] east;
        logic signed [COORD_W-1:0] zenith;
        logic                      hold;
    } vec_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]        slant;
        logic [ANGLE_W-1:0]        azim;
        logic signed [ANGLE_W-1:0] elev;
        logic                      zero_vec;
    } look_t;

    // atan(2^-i) in units of 2^-32 turn
    longint arctan_step [0:30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1
    };

    logic clk = 1'b0;
    logic rst_n;

    sezla_in_if  #(.COORD_BITS(COORD_W)) vec_if ();
    sezla_out_if #(.COORD_BITS(COORD_W), .ANGLE_BITS(ANGLE_W)) look_if ();

    sez_look_angles #(
        .CORDIC_STEPS (STEPS),
        .COORD_BITS   (COORD_W),
        .ANGLE_BITS   (ANGLE_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vec_in   (vec_if.sink),
        .look_out (look_if.source)
    );

    vec_item_t vec_queue [$];
    look_t     expected_looks [$];
    int        n_total   = 0;
    int        n_taken   = 0;
    int        n_checked = 0;
    int        n_zero    = 0;
    int        n_below   = 0;
    int        n_errors  = 0;
    logic      in_taken  = 1'b0;
    logic      calm;

    assign calm = (n_taken >= 350) && (n_taken < 550);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint turn_to_axis(inout longint x, inout longint y);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        for (int i = 0; i < STEPS && i < 31; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x   = x + dx;
                y   = y - dy;
                ang = ang + arctan_step[i];
            end
            else
            begin
                x   = x - dx;
                y   = y + dy;
                ang = ang - arctan_step[i];
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned gain_fix(input longint unsigned v);
        longint unsigned hi;
        longint unsigned lo;
        hi = v >> 30;
        lo = v & ((64'd1 << 30) - 1);
        return hi * INV_GAIN + ((lo * INV_GAIN + (64'd1 << 29)) >> 30);
    endfunction

    function automatic look_t predict_look(input logic signed [COORD_W-1:0] s_in,
                                           input logic signed [COORD_W-1:0] e_in,
                                           input logic signed [COORD_W-1:0] z_in);
        look_t           res;
        longint          s;
        longint          e;
        longint          z;
        longint          x;
        longint          y;
        longint          ang;
        longint          el;
        longint unsigned base;
        longint unsigned a32;
        longint unsigned az;
        longint unsigned h;
        longint unsigned r;
        res = '0;
        s = s_in;
        e = e_in;
        z = z_in;
        if (s == 0 && e == 0 && z == 0)
        begin
            res.zero_vec = 1'b1;
            return res;
        end
        h = 0;
        // straight up or down leaves azimuth at zero
        if (s != 0 || e != 0)
        begin
            base = 0;
            x = -(s <<< GUARD_BITS);
            y = e <<< GUARD_BITS;
            if (x < 0)
            begin
                x    = -x;
                y    = -y;
                base = 64'd1 << 31;
            end
            ang = turn_to_axis(x, y);
            a32 = (base + $unsigned(ang)) & 64'hFFFF_FFFF;
            az  = (a32 + (64'd1 << (31 - ANGLE_W))) >> (32 - ANGLE_W);
            res.azim = az[ANGLE_W-1:0];
            h = gain_fix((x < 0) ? 64'd0 : $unsigned(x));
        end
        x  = h;
        y  = z <<< GUARD_BITS;
        el = turn_to_axis(x, y);
        el = (el + (64'sd1 << (31 - ANGLE_W))) >>> (32 - ANGLE_W);
        if (el > QUARTER)
            el = QUARTER;
        if (el < -QUARTER)
            el = -QUARTER;
        r = (gain_fix((x < 0) ? 64'd0 : $unsigned(x)) + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
        if (r > RANGE_MAX)
            r = RANGE_MAX;
        res.slant = r[COORD_W-1:0];
        res.elev  = el[ANGLE_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        $display("mismatch at %0t, %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic add_vec(input logic signed [COORD_W-1:0] s,
                           input logic signed [COORD_W-1:0] e,
                           input logic signed [COORD_W-1:0] z);
        vec_queue.push_back({s, e, z, 1'b0});
        n_total++;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        int unsigned        mode;
        logic [COORD_W-1:0] raw;
        mode = $urandom_range(99);
        raw  = COORD_W'($urandom);
        if (mode < 55)
            return raw;
        if (mode < 75)
            return $signed(raw) >>> $urandom_range(COORD_W - 1, 1);
        if (mode < 85)
            return '0;
        if (mode < 92)
        begin
            case ($urandom_range(2))
                0:       return C_MAX;
                1:       return -C_MAX;
                default: return C_MIN;
            endcase
        end
        return COORD_W'($signed($urandom_range(6)) - 3);
    endfunction

    // sender
    always @(negedge clk)
    begin : drive_vec
        vec_item_t item;
        logic      next_valid;
        if (!rst_n)
            vec_if.valid <= 1'b0;
        else if (!vec_if.valid || in_taken)
        begin
            next_valid = 1'b0;
            if (vec_queue.size() > 0 && vec_queue[0].hold)
            begin
                if (expected_looks.size() == 0)
                    void'(vec_queue.pop_front());
            end
            else if (vec_queue.size() > 0 && (calm || $urandom_range(99) >= 30))
            begin
                item = vec_queue.pop_front();
                vec_if.south_m  <= item.south;
                vec_if.east_m   <= item.east;
                vec_if.zenith_m <= item.zenith;
                next_valid = 1'b1;
            end
            vec_if.valid <= next_valid;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            look_if.ready <= 1'b0;
        else
            look_if.ready <= calm || ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin : take_vec
        look_t res;
        in_taken <= rst_n && vec_if.valid && vec_if.ready;
        if (rst_n && vec_if.valid && vec_if.ready)
        begin
            res = predict_look(vec_if.south_m, vec_if.east_m, vec_if.zenith_m);
            expected_looks.push_back(res);
            n_taken++;
            if (res.zero_vec)
                n_zero++;
            if (res.elev < 0)
                n_below++;
        end
    end

    always @(posedge clk)
    begin : check_look
        look_t want;
        if (rst_n && look_if.valid && look_if.ready)
        begin
            if (expected_looks.size() == 0)
                report_mismatch("result with no vector pending", 0, 0);
            else
            begin
                want = expected_looks.pop_front();
                n_checked++;
                if (look_if.slant_range_m !== want.slant)
                    report_mismatch("slant_range_m", look_if.slant_range_m, want.slant);
                if (look_if.azimuth_bam !== want.azim)
                    report_mismatch("azimuth_bam", look_if.azimuth_bam, want.azim);
                if (look_if.elevation_bam !== want.elev)
                    report_mismatch("elevation_bam", $signed(look_if.elevation_bam),
                                    want.elev);
                if (look_if.zero_vector !== want.zero_vec)
                    report_mismatch("zero_vector", look_if.zero_vector, want.zero_vec);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still pending", expected_looks.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;

        // corners: zero vector, zenith/nadir, half turn, wrap, tiny and full scale
        add_vec(0, 0, 0);
        add_vec(0, 0, C_MAX);
        add_vec(0, 0, -C_MAX);
        add_vec(0, 0, C_MIN);
        add_vec(C_MAX, 0, 0);
        add_vec(-C_MAX, 0, 0);
        add_vec(C_MIN, 0, 0);
        add_vec(0, C_MAX, 0);
        add_vec(0, -C_MAX, 0);
        add_vec(0, C_MIN, 0);
        add_vec(-C_MAX, -1, 0);
        add_vec(-C_MAX, 1, 5);
        add_vec(C_MAX, -1, -5);
        add_vec(0, 1, C_MAX);
        add_vec(1, 0, -C_MAX);
        add_vec(C_MAX, C_MAX, C_MAX);
        add_vec(C_MIN, C_MIN, C_MIN);
        add_vec(C_MIN, C_MAX, C_MIN);
        add_vec(1, 0, 0);
        add_vec(0, -1, 0);
        add_vec(-1, -1, 1);
        add_vec(0, 0, 0);
        vec_queue.push_back({{3 * COORD_W{1'b0}}, 1'b1});

        for (int i = 0; i < 800; i++)
        begin
            if (i == 400)
                vec_queue.push_back({{3 * COORD_W{1'b0}}, 1'b1});
            if ($urandom_range(99) == 0)
                add_vec(0, 0, 0);
            else
                add_vec(pick_coord(), pick_coord(), pick_coord());
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_taken < n_total)
            @(posedge clk);
        while (expected_looks.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("checked %0d look-angle results from %0d vectors", n_checked, n_taken);
        $display("%0d zero vectors, %0d below the horizon, %0d mismatches",
                 n_zero, n_below, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
